### src/bdp_pkg.sv
// Shared types, character codes and constants for the bracketed decimal parser.
package bdp_pkg;

    localparam int MANT_W   = 54;
    localparam int FRAC_W   = 6;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 6;
    localparam int CHAR_W   = 7;

    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RESET = 6'd40;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 7'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 7'h29;
    localparam logic [CHAR_W-1:0] CH_POINT  = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 7'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_LIMIT = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [FRAC_W-1:0]      frac_digits;
        logic [MANT_W-1:0]      mantissa;
    } result_t;

    // Largest mantissa allowed: 10^digits - 1, capped to the field width.
    function automatic logic [MANT_W-1:0] mant_bound(input int digits);
        logic [63:0] p;
        logic [63:0] cap;
        p   = 64'd1;
        cap = (64'd1 << MANT_W) - 64'd1;
        for (int k = 0; k < 19; k++) begin
            if (k < digits) begin
                p = p * 64'd10;
            end
        end
        p = p - 64'd1;
        if (p > cap) begin
            p = cap;
        end
        return p[MANT_W-1:0];
    endfunction

endpackage

### src/bracketed_decimal_parser.sv
// Top level of the bracketed decimal parser: byte stream in, fixed-point results out.
// Parses a field written as "(ddd.ddd)" from a byte stream, one byte per transfer, and takes
// a new byte every clock cycle while the buffer has room. Bit 7 of each byte is ignored.
// A byte with s_axis_tuser[0] set starts a new field; bytes before '(' are skipped, and the
// field ends with one result: the digits as an unsigned mantissa, the number of digits after
// the point, and a status (0 ok, 1 bad character, 2 scan limit reached, 3 mantissa overflow;
// mantissa and digit count are zero unless ok), registered when the last byte is taken. The
// per-byte update (multiply by ten, add, compare with the bound) sits between the parse
// state registers and a two-entry output buffer, so a stalled master side holds back the
// slave side only once both buffer entries are full. cfg_wdata sets the most bytes examined
// per field (reset 40, zero acts as one); the user must write it while idle (not enforced).
module bracketed_decimal_parser
    import bdp_pkg::*;
#(
    parameter int MANTISSA_DIGITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0]         s_axis_tuser,  // [0] frame_start
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [63:0]        m_axis_tdata   // [53:0] mantissa, [59:54] frac_digits,
                                              // [61:60] status, [63:62] zero
);

    localparam logic [MANT_W-1:0] MANT_BOUND = mant_bound(MANTISSA_DIGITS);
    localparam int WIDE_W = MANT_W + 4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEEK = 2'd1,
        PH_NUM  = 2'd2
    } phase_t;

    phase_t             phase_reg,      phase_next;
    logic [LIMIT_W-1:0] byte_count_reg, byte_count_next;
    logic [MANT_W-1:0]  digit_accum_reg, digit_accum_next;
    logic [FRAC_W-1:0]  frac_count_reg, frac_count_next;
    logic               point_seen_reg, point_seen_next;
    logic [LIMIT_W-1:0] scan_limit_reg;

    phase_t             cur_phase;
    logic [LIMIT_W-1:0] cur_count;
    logic [MANT_W-1:0]  cur_accum;
    logic [FRAC_W-1:0]  cur_frac;
    logic               cur_point;

    logic [CHAR_W-1:0]  ch;
    logic               is_digit;
    logic [WIDE_W-1:0]  wide_next;
    logic               overflow;
    logic [LIMIT_W-1:0] count_inc;
    logic [LIMIT_W-1:0] limit_eff;
    logic               fin;
    status_t            fin_status;
    result_t            result;
    logic               s_accept;
    logic               buf_ready;
    result_t            m_result;

    assign s_axis_tready = buf_ready;
    assign s_accept      = s_axis_tvalid && buf_ready;
    assign m_axis_tdata  = {2'b00, m_result};

    assign ch        = s_axis_tdata[CHAR_W-1:0];
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign limit_eff = (scan_limit_reg == '0) ? LIMIT_W'(1) : scan_limit_reg;

    always_comb begin
        // frame_start restarts the field before the byte is examined
        if (s_axis_tuser[0]) begin
            cur_phase = PH_SEEK;
            cur_count = '0;
            cur_accum = '0;
            cur_frac  = '0;
            cur_point = 1'b0;
        end else begin
            cur_phase = phase_reg;
            cur_count = byte_count_reg;
            cur_accum = digit_accum_reg;
            cur_frac  = frac_count_reg;
            cur_point = point_seen_reg;
        end

        // accum * 10 + digit, accum * 10 as two shifts
        wide_next = ({4'b0000, cur_accum} << 3) + ({4'b0000, cur_accum} << 1)
                  + WIDE_W'(ch[3:0]);
        overflow  = wide_next > {4'b0000, MANT_BOUND};
        count_inc = cur_count + LIMIT_W'(1);

        phase_next       = cur_phase;
        byte_count_next  = cur_count;
        digit_accum_next = cur_accum;
        frac_count_next  = cur_frac;
        point_seen_next  = cur_point;
        fin              = 1'b0;
        fin_status       = ST_OK;

        unique case (cur_phase)
            PH_SEEK: begin
                if (ch == CH_LPAREN) begin
                    phase_next = PH_NUM;
                end
            end
            PH_NUM: begin
                priority if (ch == CH_RPAREN) begin
                    fin        = 1'b1;
                    fin_status = ST_OK;
                end else if (ch == CH_POINT) begin
                    if (cur_point) begin
                        fin        = 1'b1;
                        fin_status = ST_BAD;
                    end else begin
                        point_seen_next = 1'b1;
                    end
                end else if (is_digit) begin
                    if (overflow) begin
                        fin        = 1'b1;
                        fin_status = ST_OVER;
                    end else begin
                        digit_accum_next = wide_next[MANT_W-1:0];
                        if (cur_point) begin
                            frac_count_next = cur_frac + FRAC_W'(1);
                        end
                    end
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_BAD;
                end
            end
            default: ;
        endcase

        // the byte that reaches the limit is still examined first
        if (cur_phase != PH_IDLE && !fin) begin
            byte_count_next = count_inc;
            if (count_inc >= limit_eff) begin
                fin        = 1'b1;
                fin_status = ST_LIMIT;
            end
        end

        if (fin) begin
            phase_next = PH_IDLE;
        end

        result.status = fin_status;
        if (fin_status == ST_OK) begin
            result.mantissa    = cur_accum;
            result.frac_digits = cur_frac;
        end else begin
            result.mantissa    = '0;
            result.frac_digits = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_limit_reg  <= SCAN_LIMIT_RESET;
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= '0;
            digit_accum_reg <= '0;
            frac_count_reg  <= '0;
            point_seen_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                scan_limit_reg <= cfg_wdata;
            end
            if (s_accept) begin
                phase_reg       <= phase_next;
                byte_count_reg  <= byte_count_next;
                digit_accum_reg <= digit_accum_next;
                frac_count_reg  <= frac_count_next;
                point_seen_reg  <= point_seen_next;
            end
        end
    end

    bdp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept && fin),
        .in_data   (result),
        .in_ready  (buf_ready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_result),
        .out_ready (m_axis_tready)
    );

endmodule

### src/bdp_out_buf.sv
// Two-entry output register with skid stage for parse results.
module bdp_out_buf
    import bdp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_ready) begin
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (in_valid) begin
                    out_data_reg  <= in_data;
                    out_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (in_valid) begin
                // output stalled: park the new result
                skid_data_reg  <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule
